>>> rtl/ksa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ksa_pkg;

	// Field widths of one command and one result.
	localparam int DATA_W   = 32;
	localparam int SID_W    = 3;
	localparam int STATUS_W = 2;

	// Operation codes on func.
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BADSTACK = 2'd3;

	// Enables of the slot store for one cycle.
	typedef struct packed {
		logic rd_en;
		logic wr_link_en;
		logic wr_data_en;
	} slot_ctl_t;

endpackage

`default_nettype wire

>>> rtl/k_stacks_shared_array_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                 Payload
// command   start in, busy out        func, stack_id, push_value
// result    done out (one cycle)      pop_value, status
//
// A command is transferred when start is high and busy is low.
// A push, a failed pop or a bad stack number reads the top store and the free-list
// link, then writes back. A successful pop also reads the slot store, since it can
// only be read once the top is known, before writing back. done is registered and
// rises as the block returns to idle, so the next command can be transferred while done is high.
// Reset is asynchronous and immediate; the free list starts from a fill count,
// so no clearing pass is needed. The receiver cannot stall results.

module k_stacks_shared_array_core #(
	parameter int CAPACITY    = 16,
	parameter int STACK_COUNT = 8
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	output logic                            busy,
	input  wire                             func,
	input  wire  [ksa_pkg::SID_W-1:0]       stack_id,
	input  wire  signed [ksa_pkg::DATA_W-1:0] push_value,
	output logic                            done,
	output logic signed [ksa_pkg::DATA_W-1:0] pop_value,
	output logic [ksa_pkg::STATUS_W-1:0]    status
);
	import ksa_pkg::*;

	localparam int SW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int NW = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
	localparam logic [LW-1:0] NIL = LW'(CAPACITY);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_TOP  = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;

	logic [1:0]        state_q;
	logic              func_q;
	logic              bad_q;
	logic [NW-1:0]     sid_q;
	logic [DATA_W-1:0] value_q;
	logic [LW-1:0]     pop_slot_q;
	logic [LW-1:0]     free_head_q;
	logic [LW-1:0]     fill_q;
	logic              done_q;
	logic [DATA_W-1:0] pop_value_q;
	logic [STATUS_W-1:0] status_q;

	logic              accept;
	logic [NW-1:0]     sid_in;
	logic              bad_in;
	logic [LW-1:0]     top_val;
	logic              top_rd_en;
	logic              top_wr_en;
	logic [LW-1:0]     top_wr_val;
	slot_ctl_t         slot_ctl;
	logic [SW-1:0]     slot_rd_addr;
	logic [SW-1:0]     slot_wr_addr;
	logic [LW-1:0]     slot_wr_link;
	logic [LW-1:0]     link_rdata;
	logic [DATA_W-1:0] data_rdata;
	logic              fh_valid;
	logic              fh_fresh;
	logic              top_valid;
	logic [LW-1:0]     next_free;
	logic              pop_go;
	logic              push_go;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign sid_in = NW'(stack_id);
	assign bad_in = (32'(stack_id) >= 32'(STACK_COUNT));

	// A free-list head at or past the fill count was never used; its link is implied.
	assign fh_valid  = (free_head_q < NIL);
	assign fh_fresh  = (free_head_q >= fill_q);
	assign next_free = fh_fresh ? (free_head_q + LW'(1)) : link_rdata;
	assign top_valid = (top_val < NIL);

	// Outcome decided in S_TOP.
	assign push_go = !bad_q && (func_q == FUNC_PUSH) && fh_valid;
	assign pop_go  = !bad_q && (func_q == FUNC_POP) && top_valid;

	// Memory port control per state.
	always_comb begin
		top_rd_en    = 1'b0;
		top_wr_en    = 1'b0;
		top_wr_val   = link_rdata;
		slot_ctl     = '0;
		slot_rd_addr = free_head_q[SW-1:0];
		slot_wr_addr = free_head_q[SW-1:0];
		slot_wr_link = top_val;
		case (state_q)
			S_IDLE: begin
				top_rd_en        = accept;
				slot_ctl.rd_en   = accept;
			end
			S_TOP: begin
				if (!bad_q) begin
					if (func_q == FUNC_PUSH) begin
						if (fh_valid) begin
							slot_ctl.wr_link_en = 1'b1;
							slot_ctl.wr_data_en = 1'b1;
							top_wr_en           = 1'b1;
							top_wr_val          = free_head_q;
						end
					end else begin
						slot_ctl.rd_en = top_valid;
						slot_rd_addr   = top_val[SW-1:0];
					end
				end
			end
			S_POP: begin
				top_wr_en           = 1'b1;
				top_wr_val          = link_rdata;
				slot_ctl.wr_link_en = 1'b1;
				slot_wr_addr        = pop_slot_q[SW-1:0];
				slot_wr_link        = free_head_q;
			end
			default: begin
				top_rd_en = 1'b0;
			end
		endcase
	end

	// Sequencer, free-list head and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_head_q <= '0;
			fill_q      <= '0;
			done_q      <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (accept) begin
						state_q <= S_TOP;
					end
				end
				S_TOP: begin
					state_q <= pop_go ? S_POP : S_IDLE;
					done_q  <= !pop_go;
					if (push_go) begin
						free_head_q <= next_free;
						if (fh_fresh) begin
							fill_q <= fill_q + LW'(1);
						end
					end
				end
				S_POP: begin
					state_q     <= S_IDLE;
					done_q      <= 1'b1;
					free_head_q <= pop_slot_q;
				end
				default: begin
					state_q <= S_IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	// Command capture and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			bad_q   <= bad_in;
			sid_q   <= sid_in;
			value_q <= push_value;
		end
		case (state_q)
			S_TOP: begin
				pop_slot_q  <= top_val;
				pop_value_q <= '0;
				if (bad_q) begin
					status_q <= ST_BADSTACK;
				end else if (func_q == FUNC_PUSH) begin
					status_q <= fh_valid ? ST_DONE : ST_OVERFLOW;
				end else begin
					status_q <= top_valid ? ST_DONE : ST_EMPTY;
				end
			end
			S_POP: begin
				pop_value_q <= data_rdata;
				status_q    <= ST_DONE;
			end
			default: begin
				pop_slot_q <= pop_slot_q;
			end
		endcase
	end

	assign done      = done_q;
	assign pop_value = pop_value_q;
	assign status    = status_q;

	ksa_top_mem #(
		.CAPACITY    (CAPACITY),
		.STACK_COUNT (STACK_COUNT)
	) u_top_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (top_rd_en),
		.rd_addr (sid_in),
		.wr_en   (top_wr_en),
		.wr_addr (sid_q),
		.wr_top  (top_wr_val),
		.rdata   (top_val)
	);

	ksa_slot_mem #(
		.CAPACITY (CAPACITY)
	) u_slot_mem (
		.clk        (clk),
		.ctl        (slot_ctl),
		.rd_addr    (slot_rd_addr),
		.wr_addr    (slot_wr_addr),
		.wr_link    (slot_wr_link),
		.wr_data    (value_q),
		.link_rdata (link_rdata),
		.data_rdata (data_rdata)
	);

endmodule

`default_nettype wire

>>> rtl/ksa_slot_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module ksa_slot_mem #(
	parameter int CAPACITY = 16
) (
	input  wire                                           clk,
	input  wire ksa_pkg::slot_ctl_t                       ctl,
	input  wire  [$clog2(CAPACITY)-1:0]                   rd_addr,
	input  wire  [$clog2(CAPACITY)-1:0]                   wr_addr,
	input  wire  [$clog2(CAPACITY+1)-1:0]                 wr_link,
	input  wire  [ksa_pkg::DATA_W-1:0]                    wr_data,
	output logic [$clog2(CAPACITY+1)-1:0]                 link_rdata,
	output logic [ksa_pkg::DATA_W-1:0]                    data_rdata
);
	import ksa_pkg::*;

	localparam int LW = $clog2(CAPACITY + 1);

	logic [LW-1:0]     link_mem [CAPACITY];
	logic [DATA_W-1:0] data_mem [CAPACITY];
	logic [LW-1:0]     link_rd_q;
	logic [DATA_W-1:0] data_rd_q;

	// Link store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (ctl.wr_link_en) begin
			link_mem[wr_addr] <= wr_link;
		end
		if (ctl.rd_en) begin
			link_rd_q <= link_mem[rd_addr];
		end
	end

	// Data store: same addressing as the link store.
	always_ff @(posedge clk) begin
		if (ctl.wr_data_en) begin
			data_mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			data_rd_q <= data_mem[rd_addr];
		end
	end

	assign link_rdata = link_rd_q;
	assign data_rdata = data_rd_q;

endmodule

`default_nettype wire

>>> rtl/ksa_top_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module ksa_top_mem #(
	parameter int CAPACITY    = 16,
	parameter int STACK_COUNT = 8
) (
	input  wire                                                       clk,
	input  wire                                                       arst_n,
	input  wire                                                       rd_en,
	input  wire  [((STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1)-1:0]  rd_addr,
	input  wire                                                       wr_en,
	input  wire  [((STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1)-1:0]  wr_addr,
	input  wire  [$clog2(CAPACITY+1)-1:0]                             wr_top,
	output logic [$clog2(CAPACITY+1)-1:0]                             rdata
);
	import ksa_pkg::*;

	localparam int LW = $clog2(CAPACITY + 1);
	localparam logic [LW-1:0] NIL = LW'(CAPACITY);

	logic [LW-1:0]          top_mem [STACK_COUNT];
	logic [STACK_COUNT-1:0] vld_q;
	logic [LW-1:0]          rdata_q;
	logic                   rd_vld_q;

	// Top-of-stack store with a registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			top_mem[wr_addr] <= wr_top;
		end
		if (rd_en) begin
			rdata_q <= top_mem[rd_addr];
		end
	end

	// Valid bits: a stack never written since reset is empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rdata = rd_vld_q ? rdata_q : NIL;

endmodule

`default_nettype wire
